// ----- rtl/trend_pattern_match_counter_defines.svh -----
// Assertion macros for the trend pattern match counter
`ifndef TREND_PATTERN_MATCH_COUNTER_DEFINES_SVH
`define TREND_PATTERN_MATCH_COUNTER_DEFINES_SVH
`ifndef SYNTHESIS
`define TPMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tpmc assertion failed");
`define TPMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpmc assertion failed");
`else
`define TPMC_ASSERT(lbl, prop)
`define TPMC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/tpmc_pkg.sv -----
// Types, codes and constants shared by the trend pattern match counter
package tpmc_pkg;

  localparam int unsigned NumW       = 32;
  localparam int unsigned ResultCntW = 20;
  localparam int unsigned STdataW    = 40;
  localparam int unsigned MTdataW    = 24;

  typedef enum logic [1:0] {
    TREND_RISE  = 2'd0,
    TREND_EQUAL = 2'd1,
    TREND_FALL  = 2'd2
  } trend_e;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_NUMBER = 1'b1
  } action_e;

  typedef struct packed {
    logic    valid;
    action_e action;
    trend_e  sym;
    logic    sym_valid;
    logic    last;
  } stage_t;

  typedef struct packed {
    logic   load;
    logic   step;
    logic   clear;
    trend_e sym;
  } cell_ctrl_t;

  function automatic trend_e decode_symbol(input logic [1:0] raw);
    trend_e sym;
    case (raw)
      2'b01:   sym = TREND_RISE;
      2'b00:   sym = TREND_EQUAL;
      default: sym = TREND_FALL;
    endcase
    return sym;
  endfunction

endpackage

// ----- rtl/tpmc_cell.sv -----
// One cell of the pattern chain: a pattern symbol, its prefix hit bit and tail mark
module tpmc_cell import tpmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       sel_i,
  input  logic       hit_i,
  output logic       hit_o,
  output logic       hit_next_o,
  output logic       tail_o
);

  trend_e sym_q, sym_d;
  logic   hit_q, hit_d;
  logic   tail_q, tail_d;

  always_comb begin
    hit_next_o = ctrl_i.step ? (hit_i && (sym_q == ctrl_i.sym)) : hit_q;
    hit_d      = ctrl_i.clear ? 1'b0 : hit_next_o;
    tail_d     = ctrl_i.load ? sel_i : tail_q;
    sym_d      = (ctrl_i.load && sel_i) ? ctrl_i.sym : sym_q;
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      tail_q <= 1'b0;
    end else begin
      hit_q  <= hit_d;
      tail_q <= tail_d;
    end
  end

  assign hit_o  = hit_q;
  assign tail_o = tail_q;

endmodule

// ----- rtl/tpmc_trend.sv -----
// Front stage: previous number tracking, trend compare and symbol decode
module tpmc_trend import tpmc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic            accept_i,
  input  action_e         action_i,
  input  logic [1:0]      pattern_symbol_i,
  input  logic [NumW-1:0] number_value_i,
  input  logic            last_i,
  output stage_t          stage_o
);

  logic [NumW-1:0] prev_q, prev_d;
  logic            have_q, have_d;
  logic            valid_q, valid_d;
  stage_t          pay_q, pay_d;
  trend_e          cmp_sym;

  always_comb begin
    if ($signed(number_value_i) > $signed(prev_q)) begin
      cmp_sym = TREND_RISE;
    end else if (number_value_i == prev_q) begin
      cmp_sym = TREND_EQUAL;
    end else begin
      cmp_sym = TREND_FALL;
    end

    prev_d = prev_q;
    have_d = have_q;
    if (accept_i) begin
      if (action_i == ACT_LOAD || last_i) begin
        prev_d = '0;
        have_d = 1'b0;
      end else begin
        prev_d = number_value_i;
        have_d = 1'b1;
      end
    end

    valid_d = advance_i ? accept_i : valid_q;

    pay_d = pay_q;
    if (advance_i) begin
      pay_d.valid     = accept_i;
      pay_d.action    = action_i;
      pay_d.sym       = (action_i == ACT_LOAD) ? decode_symbol(pattern_symbol_i) : cmp_sym;
      pay_d.sym_valid = have_q;
      pay_d.last      = last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      have_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      prev_q  <= prev_d;
      have_q  <= have_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    stage_o       = pay_q;
    stage_o.valid = valid_q;
  end

endmodule

// ----- rtl/trend_pattern_match_counter.sv -----
// Trend pattern match counter: a shift-and cell chain counting trend pattern occurrences
//
// Load a pattern of 1 to MAX_PATTERN trend symbols (item with tuser 0, one symbol per
// item, tlast on the final one), then stream numbers (tuser 1). Each number after the
// first yields rise, equal or fall against its predecessor; a chain of MAX_PATTERN cells,
// one per pattern position, tracks every alignment at once and so counts overlapping
// matches. One result per number: match flag, saturating count and done (tlast). The
// block takes one item per cycle while the result side keeps up; a number's result is
// registered first in the front compare stage, then by the cell chain update and count
// into the output register. A load item or a number marked last clears the stream state;
// the pattern is kept.
module trend_pattern_match_counter import tpmc_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 64,
  parameter int unsigned COUNT_BITS  = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [STdataW-1:0] s_axis_tdata,  // pattern_symbol[1:0], number_value[33:2]
  input  logic               s_axis_tuser,  // action
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [MTdataW-1:0] m_axis_tdata,  // match_found[0], match_count[20:1]
  output logic               m_axis_tlast
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic                  advance;
  logic                  accept;
  stage_t                st;
  cell_ctrl_t            ctrl;
  logic [LenW-1:0]       len_q, len_d;
  logic                  complete_q, complete_d;
  logic [LenW-1:0]       wr_idx;
  logic [COUNT_BITS-1:0] count_q, count_d, count_new;
  logic                  is_num;
  logic                  is_load;
  logic                  found;
  logic [MAX_PATTERN-1:0] hit_q, hit_next, tail, sel;
  logic                  out_valid_q, out_valid_d;
  logic                  out_found_q, out_found_d;
  logic [ResultCntW-1:0] out_count_q, out_count_d;
  logic                  out_last_q, out_last_d;
  logic [31:0]           count_ext;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;

  tpmc_trend u_trend (
    .clk_i,
    .rst_ni,
    .advance_i        (advance),
    .accept_i         (accept),
    .action_i         (action_e'(s_axis_tuser)),
    .pattern_symbol_i (s_axis_tdata[1:0]),
    .number_value_i   (s_axis_tdata[NumW+1:2]),
    .last_i           (s_axis_tlast),
    .stage_o          (st)
  );

  assign is_num  = st.valid && (st.action == ACT_NUMBER);
  assign is_load = st.valid && (st.action == ACT_LOAD);
  assign wr_idx  = complete_q ? '0 : len_q;

  always_comb begin
    ctrl.load  = advance && is_load;
    ctrl.step  = advance && is_num && st.sym_valid && complete_q;
    ctrl.clear = advance && (is_load || (is_num && st.last));
    ctrl.sym   = st.sym;
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    assign sel[i] = (wr_idx == LenW'(i));
    tpmc_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i     (ctrl),
      .sel_i      (sel[i]),
      .hit_i      ((i == 0) ? 1'b1 : hit_q[(i == 0) ? 0 : i - 1]),
      .hit_o      (hit_q[i]),
      .hit_next_o (hit_next[i]),
      .tail_o     (tail[i])
    );
  end

  assign found     = ctrl.step && (|(hit_next & tail));
  assign count_new = (found && (count_q != CountMax)) ? count_q + 1'b1 : count_q;
  assign count_ext = 32'(count_new);

  always_comb begin
    len_d      = len_q;
    complete_d = complete_q;
    if (ctrl.load) begin
      len_d      = LenW'(wr_idx + LenW'(1));
      complete_d = st.last || (wr_idx == LenW'(MAX_PATTERN - 1));
    end

    count_d = count_q;
    if (advance && st.valid) begin
      count_d = ctrl.clear ? '0 : count_new;
    end

    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;
    if (advance) begin
      out_valid_d = is_num;
      out_found_d = found;
      out_count_d = count_ext[ResultCntW-1:0];
      out_last_d  = st.last;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      complete_q  <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      complete_q  <= complete_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(MTdataW - ResultCntW - 1){1'b0}}, out_count_q, out_found_q};
  assign m_axis_tlast  = out_last_q;

`include "trend_pattern_match_counter_defines.svh"

  `TPMC_ASSERT(a_tail_onehot0, $onehot0(tail))
  `TPMC_ASSERT(a_len_in_range, len_q <= LenW'(MAX_PATTERN))
  `TPMC_ASSERT(a_match_counts, !(out_valid_q && out_found_q) || (out_count_q != '0) || (COUNT_BITS < ResultCntW))
  `TPMC_ASSERT_NEXT(a_done_clears, advance && is_num && st.last, count_q == '0)

endmodule
